>>> rtl/tbcr_pkg.sv
// Package for the background cell renderer: configuration and queue types,
// register indexes, video mode codes and pixel counts. No dependencies.
package tbcr_pkg;

  localparam int unsigned CFG_W = 14;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VIDEO_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_FG      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_BG      = 3'd6;

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_G1   = 2'd1;
  localparam logic [1:0] MODE_G2   = 2'd2;
  localparam logic [1:0] MODE_MC   = 2'd3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [5:0] TEXT_COLUMNS = 6'd40;
  localparam logic [5:0] GFX_COLUMNS  = 6'd32;

  localparam logic [3:0] PIX_NONE = 4'd0;
  localparam logic [3:0] PIX_TEXT = 4'd6;
  localparam logic [3:0] PIX_GFX  = 4'd8;

  typedef struct packed {
    logic [1:0]  video_mode;
    logic [13:0] name_base;
    logic [13:0] pattern_base;
    logic [13:0] color_base;
    logic [1:0]  third_mask;
    logic [3:0]  text_fg;
    logic [3:0]  text_bg;
  } cfg_t;

  typedef struct packed {
    logic        is_write;
    logic        bad;
    logic [13:0] addr;
    logic [7:0]  data;
    logic [4:0]  row;
    logic [2:0]  line;
  } qent_t;

endpackage

>>> rtl/tms9918_background_cell_renderer.sv
// Top level of the background cell renderer: configuration registers,
// front end, request queue and back end. Depends on tbcr_pkg and tbcr_* modules.
//
// Channel   Direction  Handshake                 Payload
// request   in         start, busy               in_cmd, in_vram_*, in_cell_*
// result    out        out_valid (no stall)      out_pixel_0..7, out_pixel_count
// config    in         cfg_we                    cfg_index, cfg_wdata
//
// A write request writes memory as it leaves the queue. A render uses the
// read ports twice (name, then pattern and colour together), so no render
// leaves the queue while another is in its name stage. A result passes the
// name, pattern/colour and pixel stage registers. Reset clears the queue and
// the stage valids; busy rises only while the four-entry queue is full.
// VRAM_BYTES must be a power of two; addresses wrap at it.
module tms9918_background_cell_renderer #(
  parameter int unsigned VRAM_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [13:0] in_vram_address,
  input  logic [7:0]  in_vram_data,
  input  logic [4:0]  in_cell_row,
  input  logic [5:0]  in_cell_column,
  input  logic [2:0]  in_cell_line,
  output logic        out_valid,
  output logic [3:0]  out_pixel_0,
  output logic [3:0]  out_pixel_1,
  output logic [3:0]  out_pixel_2,
  output logic [3:0]  out_pixel_3,
  output logic [3:0]  out_pixel_4,
  output logic [3:0]  out_pixel_5,
  output logic [3:0]  out_pixel_6,
  output logic [3:0]  out_pixel_7,
  output logic [3:0]  out_pixel_count,
  input  logic        cfg_we,
  input  logic [tbcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbcr_pkg::CFG_W-1:0]     cfg_wdata
);

  tbcr_pkg::cfg_t  cfg_r, cfg_nxt;
  tbcr_pkg::qent_t front_ent, head;
  logic            head_valid, full, pop, accept;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tbcr_pkg::REG_VIDEO_MODE:   cfg_nxt.video_mode   = cfg_wdata[1:0];
        tbcr_pkg::REG_NAME_BASE:    cfg_nxt.name_base    = cfg_wdata;
        tbcr_pkg::REG_PATTERN_BASE: cfg_nxt.pattern_base = cfg_wdata;
        tbcr_pkg::REG_COLOR_BASE:   cfg_nxt.color_base   = cfg_wdata;
        tbcr_pkg::REG_THIRD_MASK:   cfg_nxt.third_mask   = cfg_wdata[1:0];
        tbcr_pkg::REG_TEXT_FG:      cfg_nxt.text_fg      = cfg_wdata[3:0];
        tbcr_pkg::REG_TEXT_BG:      cfg_nxt.text_bg      = cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.video_mode   <= tbcr_pkg::MODE_G1;
      cfg_r.name_base    <= '0;
      cfg_r.pattern_base <= '0;
      cfg_r.color_base   <= '0;
      cfg_r.third_mask   <= 2'd3;
      cfg_r.text_fg      <= 4'd15;
      cfg_r.text_bg      <= 4'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign busy   = full;
  assign accept = start && !full;

  tbcr_front u_front (
    .cfg          (cfg_r),
    .cmd          (in_cmd),
    .vram_address (in_vram_address),
    .vram_data    (in_vram_data),
    .cell_row     (in_cell_row),
    .cell_column  (in_cell_column),
    .cell_line    (in_cell_line),
    .ent          (front_ent)
  );

  tbcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_ent   (front_ent),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  tbcr_back #(
    .VRAM_BYTES (VRAM_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_pixel_0     (out_pixel_0),
    .out_pixel_1     (out_pixel_1),
    .out_pixel_2     (out_pixel_2),
    .out_pixel_3     (out_pixel_3),
    .out_pixel_4     (out_pixel_4),
    .out_pixel_5     (out_pixel_5),
    .out_pixel_6     (out_pixel_6),
    .out_pixel_7     (out_pixel_7),
    .out_pixel_count (out_pixel_count)
  );

  // A render holds the read ports through its name and pattern/colour reads, so results never come back to back.
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results in consecutive cycles");

  a_bad_column_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_count == tbcr_pkg::PIX_NONE) |->
      (out_pixel_0 == 4'd0 && out_pixel_3 == 4'd0 && out_pixel_7 == 4'd0))
    else $error("bad column result carries pixels");

  a_text_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_count == tbcr_pkg::PIX_TEXT) |->
      (out_pixel_6 == 4'd0 && out_pixel_7 == 4'd0))
    else $error("text result has nonzero tail pixels");

  a_reset_not_busy: assert property (@(posedge clk)
    !rst_n |=> !busy) else $error("busy right after reset");

endmodule

>>> rtl/tbcr_front.sv
// Front end: classifies each request as a memory write or a render, flags a bad
// column and forms the name table address of a render. Depends on tbcr_pkg.
module tbcr_front (
  input  tbcr_pkg::cfg_t  cfg,
  input  logic            cmd,
  input  logic [13:0]     vram_address,
  input  logic [7:0]      vram_data,
  input  logic [4:0]      cell_row,
  input  logic [5:0]      cell_column,
  input  logic [2:0]      cell_line,
  output tbcr_pkg::qent_t ent
);

  logic [13:0] row14;
  logic [13:0] row_off;
  logic        bad;

  always_comb begin
    if (cfg.video_mode == tbcr_pkg::MODE_MC) begin
      row14 = {9'd0, cell_row[4:2], 2'b00};
    end else begin
      row14 = {9'd0, cell_row};
    end
    if (cfg.video_mode == tbcr_pkg::MODE_TEXT) begin
      row_off = (row14 << 5) + (row14 << 3);
      bad     = (cell_column >= tbcr_pkg::TEXT_COLUMNS);
    end else begin
      row_off = row14 << 5;
      bad     = (cell_column >= tbcr_pkg::GFX_COLUMNS);
    end
    ent.is_write = (cmd == tbcr_pkg::CMD_WRITE);
    ent.bad      = bad;
    ent.data     = vram_data;
    ent.row      = cell_row;
    ent.line     = cell_line;
    if (cmd == tbcr_pkg::CMD_WRITE) begin
      ent.addr = vram_address;
    end else begin
      ent.addr = cfg.name_base + row_off + {8'd0, cell_column};
    end
  end

endmodule

>>> rtl/tbcr_queue.sv
// Short request queue between the front end and the render back end.
// Depends on tbcr_pkg.
module tbcr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tbcr_pkg::qent_t push_ent,
  input  logic            pop,
  output tbcr_pkg::qent_t head,
  output logic            head_valid,
  output logic            full
);

  tbcr_pkg::qent_t        slots_r [tbcr_pkg::QDEPTH];
  logic [tbcr_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tbcr_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tbcr_pkg::QAW:0]   count_r, count_nxt;

  assign head       = slots_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == (tbcr_pkg::QAW+1)'(tbcr_pkg::QDEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

>>> rtl/tbcr_back.sv
// Back end: video memory with one write and two read ports, and the
// name, pattern/colour and pixel stages. Depends on tbcr_pkg.
module tbcr_back #(
  parameter int unsigned VRAM_BYTES = 16384
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tbcr_pkg::cfg_t  cfg,
  input  tbcr_pkg::qent_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  output logic [3:0]      out_pixel_0,
  output logic [3:0]      out_pixel_1,
  output logic [3:0]      out_pixel_2,
  output logic [3:0]      out_pixel_3,
  output logic [3:0]      out_pixel_4,
  output logic [3:0]      out_pixel_5,
  output logic [3:0]      out_pixel_6,
  output logic [3:0]      out_pixel_7,
  output logic [3:0]      out_pixel_count
);

  localparam int unsigned AW = $clog2(VRAM_BYTES);

  logic [7:0]    mem [VRAM_BYTES];
  logic [7:0]    rd0_r, rd1_r;
  logic [AW-1:0] ra0, ra1;
  logic          mem_we;

  logic       s1_v_r, s1_bad_r;
  logic [4:0] s1_row_r;
  logic [2:0] s1_line_r;
  logic       s2_v_r, s2_bad_r;

  logic        pop_render;
  logic [13:0] name8, off14, pat_addr, clr_addr;
  logic [1:0]  third;

  logic [3:0]  pix_nxt [8];
  logic [3:0]  pix_r [8];
  logic [3:0]  count_nxt, count_r;
  logic        out_valid_r;
  logic [3:0]  fg, bg;

  assign pop        = head_valid && (head.is_write || !s1_v_r);
  assign pop_render = pop && !head.is_write;
  assign mem_we     = pop && head.is_write;

  always_comb begin
    name8    = {3'b000, rd0_r, 3'b000};
    third    = s1_row_r[4:3] & cfg.third_mask;
    off14    = {1'b0, third, 11'd0};
    pat_addr = cfg.pattern_base + name8 + {11'd0, s1_line_r};
    clr_addr = cfg.color_base + {9'd0, rd0_r[7:3]};
    case (cfg.video_mode)
      tbcr_pkg::MODE_G2: begin
        pat_addr = cfg.pattern_base + off14 + name8 + {11'd0, s1_line_r};
        clr_addr = cfg.color_base + off14 + name8 + {11'd0, s1_line_r};
      end
      tbcr_pkg::MODE_MC: begin
        pat_addr = cfg.pattern_base + name8 + {11'd0, s1_row_r[1:0], s1_line_r[2]};
      end
      default: begin
      end
    endcase
    ra0 = s1_v_r ? pat_addr[AW-1:0] : head.addr[AW-1:0];
    ra1 = clr_addr[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.addr[AW-1:0]] <= head.data;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_comb begin
    fg = rd1_r[7:4];
    bg = rd1_r[3:0];
    count_nxt = tbcr_pkg::PIX_GFX;
    for (int i = 0; i < 8; i++) begin
      pix_nxt[i] = rd0_r[7-i] ? fg : bg;
    end
    case (cfg.video_mode)
      tbcr_pkg::MODE_TEXT: begin
        count_nxt = tbcr_pkg::PIX_TEXT;
        for (int i = 0; i < 8; i++) begin
          pix_nxt[i] = rd0_r[7-i] ? cfg.text_fg : cfg.text_bg;
        end
        pix_nxt[6] = '0;
        pix_nxt[7] = '0;
      end
      tbcr_pkg::MODE_MC: begin
        for (int i = 0; i < 8; i++) begin
          pix_nxt[i] = (i < 4) ? rd0_r[7:4] : rd0_r[3:0];
        end
      end
      default: begin
      end
    endcase
    if (s2_bad_r) begin
      count_nxt = tbcr_pkg::PIX_NONE;
      for (int i = 0; i < 8; i++) begin
        pix_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= pop_render;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_render) begin
      s1_bad_r  <= head.bad;
      s1_row_r  <= head.row;
      s1_line_r <= head.line;
    end
    s2_bad_r <= s1_bad_r;
    if (s2_v_r) begin
      pix_r   <= pix_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_0     = pix_r[0];
  assign out_pixel_1     = pix_r[1];
  assign out_pixel_2     = pix_r[2];
  assign out_pixel_3     = pix_r[3];
  assign out_pixel_4     = pix_r[4];
  assign out_pixel_5     = pix_r[5];
  assign out_pixel_6     = pix_r[6];
  assign out_pixel_7     = pix_r[7];
  assign out_pixel_count = count_r;

endmodule
